// ===== rtl/core/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants and the rounded Q30 multiply for the sine/cosine pipeline.
// ----------------------------------------------------------------------------
package scp_pkg;

  // default formats of the angle and result words
  localparam int unsigned ANGLE_FRAC_BITS_DEF  = 28;
  localparam int unsigned RESULT_FRAC_BITS_DEF = 30;

  // internal fixed point has 30 fraction bits
  localparam int unsigned Q_FRAC = 30;
  localparam int unsigned Q_W    = 34;

  // constants in Q30, rounded to nearest; TWO_PI is twice the rounded PI
  localparam logic [Q_W-1:0] Q30_ONE     = 34'd1073741824;
  localparam logic [Q_W-1:0] Q30_PI      = 34'd3373259426;
  localparam logic [Q_W-1:0] Q30_PI_M1   = 34'd3373259425;
  localparam logic [Q_W-1:0] Q30_TWO_PI  = 34'd6746518852;
  localparam logic [Q_W-1:0] Q30_HALF_PI = 34'd1686629713;
  localparam logic [Q_W-1:0] Q30_INV2    = 34'd536870912;
  localparam logic [Q_W-1:0] Q30_INV6    = 34'd178956971;
  localparam logic [Q_W-1:0] Q30_INV24   = 34'd44739243;
  localparam logic [Q_W-1:0] Q30_INV120  = 34'd8947849;
  localparam logic [Q_W-1:0] Q30_INV720  = 34'd1491308;
  localparam logic [Q_W-1:0] Q30_INV5040 = 34'd213044;

  // product of two non-negative Q30 magnitudes, rounded half up to Q30
  function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a,
                                          input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] p;
    p = (2*Q_W)'(a) * (2*Q_W)'(b) + ((2*Q_W)'(1) << (Q_FRAC - 1));
    return p[Q_W+Q_FRAC-1:Q_FRAC];
  endfunction

endpackage

// ===== rtl/core/sine_cosine_polynomial.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_polynomial
// Pipelined sine/cosine of a fixed-point angle: turn reduction by restoring
// subtraction of 2pi multiples, quadrant fold, then Taylor polynomial.
// ----------------------------------------------------------------------------
//  channel   signals                         word
//  -------   -----------------------------   ---------------------------------
//  arg       arg_valid, arg_ready            kind (0 sin, 1 cos), angle Q4.28
//  res       res_valid, res_ready            value Q2.30
//
//  one word accepted per cycle when res_ready stays high
//  KM_BITS (1 at the default angle format) is the number of 2pi subtract
//  stages the angle range needs
//  rst is synchronous and clears only the stage valid bits
//  each stage holds its word while the one after it is full and stalled;
//  empty stages keep filling, so words are taken while a result waits
// ----------------------------------------------------------------------------
module sine_cosine_polynomial #(
  parameter int unsigned ANGLE_FRAC_BITS  = scp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               arg_valid,
  output logic               arg_ready,
  input  logic               kind,
  input  logic signed [31:0] angle,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] value
);

  import scp_pkg::*;

  // derived sizes
  localparam int unsigned SHIFT   = Q_FRAC - ANGLE_FRAC_BITS;
  localparam int unsigned N_W     = (ANGLE_FRAC_BITS > 28) ? 34 : 62 - ANGLE_FRAC_BITS;
  localparam longint unsigned M_MAX  = 64'd1 << (61 - ANGLE_FRAC_BITS);
  localparam longint unsigned KM_MAX = (M_MAX + 64'(Q30_PI_M1)) / 64'(Q30_TWO_PI);
  localparam int unsigned KM_BITS = $clog2(KM_MAX + 1);
  localparam int unsigned OUT_SH  = Q_FRAC - RESULT_FRAC_BITS;
  localparam logic [32:0] OUT_HALF = 33'(33'd1 << OUT_SH) >> 1;

  // stage positions
  localparam int unsigned ST_D  = KM_BITS + 1;
  localparam int unsigned ST_E  = KM_BITS + 2;
  localparam int unsigned ST_P1 = KM_BITS + 3;
  localparam int unsigned ST_P2 = KM_BITS + 4;
  localparam int unsigned ST_P3 = KM_BITS + 5;
  localparam int unsigned ST_P4 = KM_BITS + 6;
  localparam int unsigned ST_P5 = KM_BITS + 7;
  localparam int unsigned ST_O  = KM_BITS + 8;
  localparam int unsigned NS    = KM_BITS + 9;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // stage valid bits and per-stage load enables
  always_comb begin
    en[NS-1] = !vld[NS-1] || res_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= arg_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign arg_ready = en[0];
  assign res_valid = vld[ST_O];

  // input stage: magnitude in Q30, offset for the ceiling of the turn count
  logic [N_W-1:0] dv_rem  [0:KM_BITS];
  logic           dv_kind [0:KM_BITS];
  logic           dv_neg  [0:KM_BITS];
  logic [31:0]    ang_mag;

  assign ang_mag = angle[31] ? 32'(-angle) : 32'(angle);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dv_rem[0]  <= (N_W'(ang_mag) << SHIFT) + N_W'(Q30_PI_M1);
      dv_kind[0] <= kind;
      dv_neg[0]  <= angle[31];
    end
  end

  // restoring subtraction of 2pi multiples, one quotient bit per stage
  for (genvar g = 1; g <= KM_BITS; g++) begin : g_div
    localparam int unsigned B = KM_BITS - g;
    localparam logic [N_W-1:0] DK = N_W'(Q30_TWO_PI) << B;
    always_ff @(posedge clk) begin
      if (en[g]) begin
        if (dv_rem[g-1] >= DK) begin
          dv_rem[g] <= dv_rem[g-1] - DK;
        end else begin
          dv_rem[g] <= dv_rem[g-1];
        end
        dv_kind[g] <= dv_kind[g-1];
        dv_neg[g]  <= dv_neg[g-1];
      end
    end
  end

  // reduced angle magnitude and sign
  logic signed [34:0] ym;
  logic [31:0]        d_am;
  logic               d_sg;
  logic               d_kind;

  assign ym = $signed({2'b00, dv_rem[KM_BITS][32:0]}) - $signed(35'(Q30_PI_M1));

  always_ff @(posedge clk) begin
    if (en[ST_D]) begin
      d_am   <= ym[34] ? 32'(-ym) : 32'(ym);
      d_sg   <= dv_neg[KM_BITS] ^ ym[34];
      d_kind <= dv_kind[KM_BITS];
    end
  end

  // quadrant fold into -pi/2..pi/2
  logic [30:0] e_xm;
  logic        e_sg;
  logic        e_fold;
  logic        e_kind;

  always_ff @(posedge clk) begin
    if (en[ST_E]) begin
      if (34'(d_am) > Q30_HALF_PI) begin
        e_xm   <= 31'(Q30_PI - 34'(d_am));
        e_fold <= 1'b1;
      end else begin
        e_xm   <= d_am[30:0];
        e_fold <= 1'b0;
      end
      e_sg   <= d_sg;
      e_kind <= d_kind;
    end
  end

  // x squared
  logic [31:0] p1_x2;
  logic [30:0] p1_xm;
  logic        p1_sg;
  logic        p1_fold;
  logic        p1_kind;

  always_ff @(posedge clk) begin
    if (en[ST_P1]) begin
      p1_x2   <= 32'(qmul(34'(e_xm), 34'(e_xm)));
      p1_xm   <= e_xm;
      p1_sg   <= e_sg;
      p1_fold <= e_fold;
      p1_kind <= e_kind;
    end
  end

  // x to the fourth and the first series term
  logic [32:0] p2_x4;
  logic [31:0] p2_x2;
  logic [31:0] p2_t1;
  logic [30:0] p2_xm;
  logic        p2_sg;
  logic        p2_fold;
  logic        p2_kind;

  always_ff @(posedge clk) begin
    if (en[ST_P2]) begin
      p2_x4   <= 33'(qmul(34'(p1_x2), 34'(p1_x2)));
      p2_t1   <= 32'(qmul(34'(p1_x2), p1_kind ? Q30_INV2 : Q30_INV6));
      p2_x2   <= p1_x2;
      p2_xm   <= p1_xm;
      p2_sg   <= p1_sg;
      p2_fold <= p1_fold;
      p2_kind <= p1_kind;
    end
  end

  // x to the sixth, second term and partial sum
  logic [33:0]        p3_x6;
  logic signed [35:0] p3_acc;
  logic [30:0]        p3_xm;
  logic               p3_sg;
  logic               p3_fold;
  logic               p3_kind;
  logic [31:0]        t2;

  assign t2 = 32'(qmul(34'(p2_x4), p2_kind ? Q30_INV24 : Q30_INV120));

  always_ff @(posedge clk) begin
    if (en[ST_P3]) begin
      p3_x6   <= qmul(34'(p2_x4), 34'(p2_x2));
      p3_acc  <= $signed({2'b00, Q30_ONE}) - $signed({4'b0000, p2_t1})
                 + $signed({4'b0000, t2});
      p3_xm   <= p2_xm;
      p3_sg   <= p2_sg;
      p3_fold <= p2_fold;
      p3_kind <= p2_kind;
    end
  end

  // last term closes the series
  logic signed [35:0] p4_s;
  logic [30:0]        p4_xm;
  logic               p4_sg;
  logic               p4_fold;
  logic               p4_kind;
  logic [31:0]        t3;

  assign t3 = 32'(qmul(p3_x6, p3_kind ? Q30_INV720 : Q30_INV5040));

  always_ff @(posedge clk) begin
    if (en[ST_P4]) begin
      p4_s    <= p3_acc - $signed({4'b0000, t3});
      p4_xm   <= p3_xm;
      p4_sg   <= p3_sg;
      p4_fold <= p3_fold;
      p4_kind <= p3_kind;
    end
  end

  // sine multiplies by x; cosine takes the sum, negated when folded
  logic [31:0] p5_rm;
  logic        p5_neg;
  logic [31:0] s_abs;

  assign s_abs = p4_s[35] ? 32'(-p4_s) : 32'(p4_s);

  always_ff @(posedge clk) begin
    if (en[ST_P5]) begin
      if (p4_kind) begin
        p5_rm  <= s_abs;
        p5_neg <= p4_s[35] ^ p4_fold;
      end else begin
        p5_rm  <= 32'(qmul(34'(p4_xm), p4_s[33:0]));
        p5_neg <= p4_sg;
      end
    end
  end

  // round to the result format and apply the sign
  logic [32:0] rnd;

  assign rnd = ({1'b0, p5_rm} + OUT_HALF) >> OUT_SH;

  always_ff @(posedge clk) begin
    if (en[ST_O]) begin
      value <= p5_neg ? -$signed(rnd[31:0]) : $signed(rnd[31:0]);
    end
  end

  // checks
  a_empty_ready : assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> arg_ready)
    else $error("input stalled with an empty output stage");

  a_reset_clear : assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_fold_range : assert property (@(posedge clk) disable iff (rst)
    vld[ST_E] |-> (34'(e_xm) <= Q30_HALF_PI))
    else $error("folded angle beyond pi/2");

  a_turn_range : assert property (@(posedge clk) disable iff (rst)
    vld[KM_BITS] |-> (dv_rem[KM_BITS] < N_W'(Q30_TWO_PI)))
    else $error("turn reduction left more than one turn");

  a_unit_bound : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((value <= $signed(32'd1 << RESULT_FRAC_BITS)) &&
                   (value >= -$signed(32'd1 << RESULT_FRAC_BITS))))
    else $error("result magnitude above one");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sine_cosine_polynomial. A directed table covers the
// zero, fold and turn edges and the extremes of the angle. Random words
// follow, spread over the full Q4.28 range and bunched near the edges. Every
// untyped word is predicted bit for bit in Q30; every word is checked in
// order. Both channels idle at random, with gap-free bursts between.
// ----------------------------------------------------------------------------
module tb;

  // function selector codes
  localparam logic KIND_SINE   = 1'b0;
  localparam logic KIND_COSINE = 1'b1;

  // Q30 constants, rounded to nearest; TWO_PI_Q30 is twice the rounded PI_Q30
  localparam longint ONE_Q30      = 64'sd1073741824;
  localparam longint PI_Q30       = 64'sd3373259426;
  localparam longint TWO_PI_Q30   = 64'sd6746518852;
  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint INV2_Q30     = 64'sd536870912;
  localparam longint INV6_Q30     = 64'sd178956971;
  localparam longint INV24_Q30    = 64'sd44739243;
  localparam longint INV120_Q30   = 64'sd8947849;
  localparam longint INV720_Q30   = 64'sd1491308;
  localparam longint INV5040_Q30  = 64'sd213044;

  localparam int ANGLE_SHIFT = 30 - scp_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int RES_SHIFT   = 30 - scp_pkg::RESULT_FRAC_BITS_DEF;

  // angle words (Q4.28) just past pi/2 and pi, and just short of one full turn
  localparam int HALF_PI_ANG = 421657429;
  localparam int PI_ANG      = 843314857;
  localparam int TURN_ANG    = 1686629713;

  localparam int RANDOM_WORDS = 950;
  localparam int IDLE_LIMIT   = 1000;
  localparam int BURST_SPAN   = 50;
  localparam int MAX_GAP      = 17;

  // one row of the directed table: input word, and a typed result if known
  typedef struct packed {
    logic               kind;
    logic signed [31:0] angle;
    logic               typed;
    logic signed [31:0] want;
  } stim_row_t;

  // expectation held until the matching result word arrives
  typedef struct {
    logic               kind;
    logic signed [31:0] angle;
    logic signed [31:0] value;
  } pending_t;

  localparam int NUM_DIRECTED = 24;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    {KIND_COSINE, 32'sd0,              1'b1, 32'sd1073741824},
    {KIND_SINE,   32'sd0,              1'b1, 32'sd0},
    {KIND_COSINE, 32'sd1,              1'b1, 32'sd1073741824},
    {KIND_COSINE, -32'sd1,             1'b1, 32'sd1073741824},
    {KIND_SINE,   32'sd1686629713,     1'b1, 32'sd0},
    {KIND_COSINE, -32'sd1686629713,    1'b1, 32'sd1073741824},
    {KIND_SINE,   32'sd2147483647,     1'b0, 32'sd0},
    {KIND_SINE,   -32'sd2147483648,    1'b0, 32'sd0},
    {KIND_COSINE, 32'sd2147483647,     1'b0, 32'sd0},
    {KIND_COSINE, -32'sd2147483648,    1'b0, 32'sd0},
    {KIND_SINE,   32'sd421657428,      1'b0, 32'sd0},
    {KIND_SINE,   32'sd421657429,      1'b0, 32'sd0},
    {KIND_SINE,   -32'sd421657428,     1'b0, 32'sd0},
    {KIND_SINE,   -32'sd421657429,     1'b0, 32'sd0},
    {KIND_COSINE, 32'sd421657428,      1'b0, 32'sd0},
    {KIND_COSINE, 32'sd421657429,      1'b0, 32'sd0},
    {KIND_COSINE, -32'sd421657429,     1'b0, 32'sd0},
    {KIND_SINE,   32'sd843314856,      1'b0, 32'sd0},
    {KIND_SINE,   32'sd843314857,      1'b0, 32'sd0},
    {KIND_SINE,   -32'sd843314857,     1'b0, 32'sd0},
    {KIND_COSINE, -32'sd843314856,     1'b0, 32'sd0},
    {KIND_COSINE, -32'sd843314857,     1'b0, 32'sd0},
    {KIND_SINE,   32'sh55555555,       1'b0, 32'sd0},
    {KIND_COSINE, 32'sh2AAAAAAA,       1'b0, 32'sd0}
  };

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               arg_valid = 1'b0;
  logic               arg_ready;
  logic               kind      = KIND_SINE;
  logic signed [31:0] angle     = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic signed [31:0] value;

  pending_t pending_values[$];
  int       words_sent    = 0;
  int       values_seen   = 0;
  int       mismatches    = 0;
  int       idle_cycles   = 0;
  bit       arg_burst     = 1'b0;
  bit       res_burst     = 1'b0;

  sine_cosine_polynomial u_dut (
    .clk       (clk),
    .rst       (rst),
    .arg_valid (arg_valid),
    .arg_ready (arg_ready),
    .kind      (kind),
    .angle     (angle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .value     (value)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Q30 by Q30 product, rounded to nearest with ties away from zero
  function automatic longint mul_q30(input longint a, input longint b);
    logic [127:0]    mag;
    longint unsigned ma;
    longint unsigned mb;
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    mag = ({64'd0, ma} * {64'd0, mb} + (128'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  // seventh-order sine series on a folded Q30 angle
  function automatic longint taylor_sine(input longint x);
    longint x2, x4, x6, s;
    x2 = mul_q30(x, x);
    x4 = mul_q30(x2, x2);
    x6 = mul_q30(x4, x2);
    s  = ONE_Q30 - mul_q30(x2, INV6_Q30) + mul_q30(x4, INV120_Q30)
         - mul_q30(x6, INV5040_Q30);
    return mul_q30(x, s);
  endfunction

  // sixth-order cosine series on a folded Q30 angle
  function automatic longint taylor_cosine(input longint x);
    longint x2, x4, x6;
    x2 = mul_q30(x, x);
    x4 = mul_q30(x2, x2);
    x6 = mul_q30(x4, x2);
    return ONE_Q30 - mul_q30(x2, INV2_Q30) + mul_q30(x4, INV24_Q30)
           - mul_q30(x6, INV720_Q30);
  endfunction

  // expected result word for one input word
  function automatic logic signed [31:0] sin_cos_value(input logic k,
                                                       input logic signed [31:0] a);
    longint          x;
    longint          r;
    longint unsigned mag;
    x = longint'(a) * (longint'(1) << ANGLE_SHIFT);
    // whole turns into -pi..pi
    if (x > PI_Q30)
      x -= ((x - PI_Q30 + TWO_PI_Q30 - 1) / TWO_PI_Q30) * TWO_PI_Q30;
    else if (x < -PI_Q30)
      x += ((-PI_Q30 - x + TWO_PI_Q30 - 1) / TWO_PI_Q30) * TWO_PI_Q30;
    // quadrant fold
    if (k == KIND_SINE) begin
      if (x > HALF_PI_Q30)
        x = PI_Q30 - x;
      else if (x < -HALF_PI_Q30)
        x = -PI_Q30 - x;
      r = taylor_sine(x);
    end else begin
      if (x > HALF_PI_Q30)
        r = -taylor_cosine(PI_Q30 - x);
      else if (x < -HALF_PI_Q30)
        r = -taylor_cosine(PI_Q30 + x);
      else
        r = taylor_cosine(x);
    end
    // round to the result format
    mag = (r < 0) ? -r : r;
    mag = (mag + ((longint'(1) << RES_SHIFT) >> 1)) >> RES_SHIFT;
    r   = (r < 0) ? -longint'(mag) : longint'(mag);
    return r[31:0];
  endfunction

  // drive one word after a random gap, none in a burst; returns at the accepting edge
  task automatic send_angle(input logic k, input logic signed [31:0] a,
                            input logic typed, input logic signed [31:0] want);
    int       gap;
    pending_t p;
    gap = arg_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      arg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    arg_valid <= 1'b1;
    kind      <= k;
    angle     <= a;
    @(negedge clk);
    while (!arg_ready) @(negedge clk);
    p.kind  = k;
    p.angle = a;
    p.value = typed ? want : sin_cos_value(k, a);
    pending_values.push_back(p);
    @(posedge clk);
    words_sent++;
    if (words_sent % BURST_SPAN == 0) arg_burst = ($urandom_range(0, 2) == 0);
  endtask

  // sender holds off until every expected word has come back
  task automatic drain_results();
    arg_valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int                 sel;
    int                 edge_sel;
    logic               k;
    logic signed [31:0] a;
    int                 edges [9];
    edges = '{0, HALF_PI_ANG, -HALF_PI_ANG, PI_ANG, -PI_ANG, TURN_ANG, -TURN_ANG,
              32'sh7FFFFFFF, 32'sh80000000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_angle(DIRECTED[i].kind, DIRECTED[i].angle, DIRECTED[i].typed,
                 DIRECTED[i].want);
    drain_results();

    // random words, bunched near zero and the fold and turn edges
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) drain_results();
      k   = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 5);
      case (sel)
        0, 1, 2: a = $urandom;
        3:       a = $urandom_range(0, 2 * PI_ANG) - PI_ANG;
        4: begin
          edge_sel = $urandom_range(0, 8);
          a = edges[edge_sel] + $urandom_range(0, 64) - 32;
        end
        default: a = $urandom_range(0, 2048) - 1024;
      endcase
      send_angle(k, a, 1'b0, 32'sd0);
    end
    arg_valid <= 1'b0;

    // wait for the tail, then keep watching for any stray word
    while (pending_values.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("tb: %0d angle words driven (%0d from the table), %0d values checked, %0d mismatches",
             words_sent, NUM_DIRECTED, values_seen, mismatches);
    $display("tb: sine and cosine over the full Q4.28 range, fold and turn edges, random gaps");
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // result side: random stalls, in-order check against the oldest expectation
  initial begin
    int       stall;
    pending_t p;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = res_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(negedge clk);
      while (!res_valid) @(negedge clk);
      if (pending_values.size() == 0) begin
        $error("value: no word expected, got %0d", value);
        mismatches++;
      end else begin
        p = pending_values.pop_front();
        if (value !== p.value) begin
          $error("value: expected %0d, actual %0d (kind %0d, angle %0d)",
                 p.value, value, p.kind, p.angle);
          mismatches++;
        end
      end
      @(posedge clk);
      values_seen++;
      if (values_seen % BURST_SPAN == 0) res_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(negedge clk) begin
    if (!rst) begin
      if ((arg_valid && arg_ready) || (res_valid && res_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: no word moved for %0d cycles, %0d still expected",
                 IDLE_LIMIT, pending_values.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/scp_pkg.sv
rtl/core/sine_cosine_polynomial.sv
dv/tb.sv
